// File: sv/hsfc_pkg.sv
// hsfc_pkg: shared types and constants for the half/single float converter
// stage records, classification codes and format constants
// no dependencies
package hsfc_pkg;

    typedef enum logic {
        CMD_H2S = 1'b0,
        CMD_S2H = 1'b1
    } cmd_t;

    // operand class, decided in the first stage
    typedef enum logic [2:0] {
        CLS_ZERO,
        CLS_SUB,
        CLS_NORM,
        CLS_INF,
        CLS_NAN
    } cls_t;

    localparam logic [7:0]  H2S_EXP_ADJ  = 8'd112;
    localparam logic [7:0]  H2S_SUB_BASE = 8'd113;
    localparam logic [9:0]  S2H_EXP_ADJ  = 10'd112;
    localparam logic [9:0]  S2H_SUB_TOP  = 10'd14;
    localparam logic [23:0] ROUND_BIAS   = 24'h000fff;
    localparam logic [23:0] HIDDEN_BIT   = 24'h800000;
    localparam logic [9:0]  QNAN_BIT     = 10'h200;
    localparam logic [4:0]  HALF_EXP_MAX = 5'd31;
    localparam logic [4:0]  HALF_EXP_TOP = 5'd30;
    localparam logic [4:0]  HALF_WIDTH_M = 5'd10;

    // after decode
    typedef struct packed {
        cmd_t        cmd;
        logic        sign;
        cls_t        cls;
        logic [4:0]  exp;
        logic [23:0] frac;
        logic [4:0]  shamt;
    } s1_t;

    // after shift / round add
    typedef struct packed {
        cmd_t        cmd;
        logic        sign;
        cls_t        cls;
        logic [7:0]  exp;
        logic [23:0] man;
        logic        rnd;
        logic        stk;
    } s2_t;

endpackage

// File: sv/half_single_float_converter.sv
// half_single_float_converter: binary16 <-> binary32 bit pattern conversion
// an accepted beat passes stages 1, 2 and 3 to the result; one beat per cycle while result_stall is low
// each of the three stages loads when empty or when the stage after it moves
// reset (rst_n low, asynchronous) empties all stages; payload is not reset
// item_stall rises only when all three stages hold beats and result_stall is high
// depends on hsfc_pkg
module half_single_float_converter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic        command,
    input  logic [31:0] operand,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [31:0] converted
);
    import hsfc_pkg::*;

    // stage valids and payload registers
    logic        v1_reg, v2_reg, v3_reg;
    s1_t         s1_reg, s1_next;
    s2_t         s2_reg, s2_next;
    logic [31:0] conv_reg, conv_next;
    cmd_t        cmd3_reg;

    // per-stage load enables, a stage moves when it is empty or its successor moves
    logic ready1, ready2, ready3;

    assign ready3 = !v3_reg || !result_stall;
    assign ready2 = !v2_reg || ready3;
    assign ready1 = !v1_reg || ready2;

    assign item_stall   = !ready1;
    assign result_valid = v3_reg;
    assign converted    = conv_reg;

    // ---------------- stage 1: unpack and classify ----------------
    logic [4:0]        lz_shift;
    logic              lz_found;
    logic [7:0]        bexp;
    logic [22:0]       f23;
    logic signed [9:0] e_s;
    logic signed [9:0] sh_full;

    // shift that brings the leading one of a subnormal half fraction to bit 10
    always_comb
    begin
        lz_shift = HALF_WIDTH_M;
        lz_found = 1'b0;
        for (int i = 9; i >= 0; i--)
        begin
            if (!lz_found && operand[i])
            begin
                lz_shift = 5'(10 - i);
                lz_found = 1'b1;
            end
        end
    end

    assign bexp    = operand[30:23];
    assign f23     = operand[22:0];
    assign e_s     = $signed({2'b00, bexp}) - $signed(S2H_EXP_ADJ);
    assign sh_full = $signed(S2H_SUB_TOP) - e_s;

    always_comb
    begin
        s1_next       = '0;
        s1_next.cmd   = cmd_t'(command);
        if (cmd_t'(command) == CMD_H2S)
        begin
            // upper 16 operand bits are ignored in this direction
            s1_next.sign  = operand[15];
            s1_next.exp   = operand[14:10];
            s1_next.frac  = {14'b0, operand[9:0]};
            s1_next.shamt = lz_shift;
            if (operand[14:10] == 5'd0)
                s1_next.cls = (operand[9:0] == 10'd0) ? CLS_ZERO : CLS_SUB;
            else if (operand[14:10] == HALF_EXP_MAX)
                s1_next.cls = CLS_NAN;      // inf and nan both keep the payload
            else
                s1_next.cls = CLS_NORM;
        end
        else
        begin
            s1_next.sign = operand[31];
            s1_next.frac = {1'b0, f23};
            if (bexp == 8'hff)
                s1_next.cls = (f23 != 23'd0) ? CLS_NAN : CLS_INF;
            else if (e_s >= 10'sd31)
                s1_next.cls = CLS_INF;      // overflow
            else if (e_s < -10'sd10)
                s1_next.cls = CLS_ZERO;     // below half the smallest subnormal
            else if (e_s <= 10'sd0)
            begin
                // subnormal half: hidden bit made explicit, shift of 14..24
                s1_next.cls   = CLS_SUB;
                s1_next.frac  = HIDDEN_BIT | {1'b0, f23};
                s1_next.shamt = sh_full[4:0];
            end
            else
            begin
                s1_next.cls = CLS_NORM;
                s1_next.exp = e_s[4:0];
            end
        end
    end

    // ---------------- stage 2: normalize shift, align and round add ----------------
    logic [20:0] h_shifted;
    logic [23:0] sub_mask;
    logic [4:0]  rnd_pos;

    assign h_shifted = {11'b0, s1_reg.frac[9:0]} << s1_reg.shamt;
    assign rnd_pos   = s1_reg.shamt - 5'd1;
    assign sub_mask  = (24'd1 << rnd_pos) - 24'd1;

    always_comb
    begin
        s2_next      = '0;
        s2_next.cmd  = s1_reg.cmd;
        s2_next.sign = s1_reg.sign;
        s2_next.cls  = s1_reg.cls;
        s2_next.man  = s1_reg.frac;
        if (s1_reg.cmd == CMD_H2S)
        begin
            case (s1_reg.cls)
                CLS_SUB:
                begin
                    s2_next.man = {14'b0, h_shifted[9:0]};
                    s2_next.exp = H2S_SUB_BASE - {3'b0, s1_reg.shamt};
                end
                CLS_NORM: s2_next.exp = {3'b0, s1_reg.exp} + H2S_EXP_ADJ;
                CLS_NAN:  s2_next.exp = 8'hff;
                default:  s2_next.exp = 8'd0;
            endcase
        end
        else
        begin
            s2_next.exp = {3'b0, s1_reg.exp};
            case (s1_reg.cls)
                CLS_SUB:
                begin
                    s2_next.man = s1_reg.frac >> s1_reg.shamt;
                    s2_next.rnd = s1_reg.frac[rnd_pos];
                    s2_next.stk = |(s1_reg.frac & sub_mask);
                end
                CLS_NORM:
                    // nearest even: bias plus the lsb that survives the cut
                    s2_next.man = s1_reg.frac + ROUND_BIAS + {23'b0, s1_reg.frac[13]};
                default: s2_next.man = s1_reg.frac;
            endcase
        end
    end

    // ---------------- stage 3: final increment and pack ----------------
    logic [10:0] kept_r;
    logic [4:0]  exp_inc;

    assign kept_r  = s2_reg.man[10:0]
                   + {10'b0, s2_reg.rnd && (s2_reg.stk || s2_reg.man[0])};
    assign exp_inc = s2_reg.exp[4:0] + 5'd1;

    always_comb
    begin
        conv_next = '0;
        if (s2_reg.cmd == CMD_H2S)
        begin
            case (s2_reg.cls)
                CLS_ZERO: conv_next = {s2_reg.sign, 31'b0};
                default:  conv_next = {s2_reg.sign, s2_reg.exp, s2_reg.man[9:0], 13'b0};
            endcase
        end
        else
        begin
            case (s2_reg.cls)
                CLS_NAN:
                    conv_next = {16'b0, s2_reg.sign, HALF_EXP_MAX,
                                 s2_reg.man[22:13] | QNAN_BIT};
                CLS_INF:
                    conv_next = {16'b0, s2_reg.sign, HALF_EXP_MAX, 10'b0};
                CLS_SUB:
                    // a carry into bit 10 lands on the smallest normal
                    conv_next = {16'b0, s2_reg.sign, 4'b0, kept_r};
                CLS_NORM:
                begin
                    if (s2_reg.man[23])
                    begin
                        // carry out of the fraction bumps the exponent
                        if (s2_reg.exp[4:0] == HALF_EXP_TOP)
                            conv_next = {16'b0, s2_reg.sign, HALF_EXP_MAX, 10'b0};
                        else
                            conv_next = {16'b0, s2_reg.sign, exp_inc, 10'b0};
                    end
                    else
                        conv_next = {16'b0, s2_reg.sign, s2_reg.exp[4:0],
                                     s2_reg.man[22:13]};
                end
                default:
                    conv_next = {16'b0, s2_reg.sign, 15'b0};
            endcase
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (ready1)
                v1_reg <= item_valid;
            if (ready2)
                v2_reg <= v1_reg;
            if (ready3)
                v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready1 && item_valid)
            s1_reg <= s1_next;
        if (ready2 && v1_reg)
            s2_reg <= s2_next;
        if (ready3 && v2_reg)
        begin
            conv_reg <= conv_next;
            cmd3_reg <= s2_reg.cmd;
        end
    end

    // ---------------- assertions ----------------
    a_stage_moves : assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && ready2) |=> v2_reg)
        else $error("stage 1 beat lost on advance");

    a_stall_only_full : assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (v1_reg && v2_reg && v3_reg && result_stall))
        else $error("input stalled with a free stage");

    a_half_zero_ext : assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && cmd3_reg == CMD_S2H) |-> (converted[31:16] == 16'd0))
        else $error("half result not zero-extended");

    a_sub_shift : assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && s1_reg.cmd == CMD_S2H && s1_reg.cls == CLS_SUB)
            |-> (s1_reg.shamt >= 5'd14 && s1_reg.shamt <= 5'd24))
        else $error("subnormal shift out of range");

endmodule
